/* rtl/core/slq_pkg.sv */
// slq_pkg: types and codes shared by the sorted list queue modules
// item formats, opcode and status codes, controller command bundle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slq_pkg;

  // opcodes of one request item
  localparam logic [1:0] OP_INSERT     = 2'd0;
  localparam logic [1:0] OP_REM_MIN    = 2'd1;
  localparam logic [1:0] OP_REM_MAX    = 2'd2;
  localparam logic [1:0] OP_REM_SECOND = 2'd3;

  // status codes of one response item
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        entry_count;
  } rsp_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the request item
    logic exec;   // apply the item to the cell row and register the response
  } slq_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/slq_ctrl.sv */
// slq_ctrl: controller of the sorted list queue
// sequences accept and execute steps and owns both handshakes
// depends on slq_pkg
`timescale 1ns / 1ps
`default_nettype none

module slq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output slq_pkg::slq_cmd_t      cmd
);
  import slq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   exec_go;

  // response slot is free when empty or being taken this cycle
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || !rsp_stall);
  assign req_stall = (state != S_IDLE);
  assign cmd.load  = (state == S_IDLE) && req_valid;
  assign cmd.exec  = exec_go;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/slq_datapath.sv */
// slq_datapath: row of compare-and-shift cells holding the sorted values
// plus the entry count, request register and response register
// depends on slq_pkg
`timescale 1ns / 1ps
`default_nettype none

module slq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire slq_pkg::slq_cmd_t cmd,
  input  wire slq_pkg::req_item_t req,
  output slq_pkg::rsp_item_t     rsp
);
  import slq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  req_item_t                 item;
  logic signed [VALUE_W-1:0] cells      [CAPACITY];
  logic signed [VALUE_W-1:0] ins_cell   [CAPACITY];
  logic signed [VALUE_W-1:0] rem_cell   [CAPACITY];
  logic [VALUE_W-1:0]        tail_term  [CAPACITY];
  logic [CAPACITY-1:0]       gt;
  logic [CAPACITY-1:0]       rem_shift;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W+COUNT_W-1:0]  count_ext;
  logic [VALUE_W-1:0]        tail_value;
  logic signed [VALUE_W-1:0] removed;
  logic [1:0]                stat;
  logic                      do_insert;
  logic                      do_remove;

  // request register
  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
  end

  // per-cell compare, insert shift and removal shift
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    // empty cells and cells above the new value open the insert slot
    assign gt[g] = (count <= CNT_W'(g)) || (cells[g] > item.value);

    if (g == 0) begin : g_first
      assign ins_cell[g] = gt[g] ? item.value : cells[g];
    end else begin : g_rest
      assign ins_cell[g] = gt[g] ? (gt[g-1] ? cells[g-1] : item.value) : cells[g];
    end

    // cells at or above the removed position take their upper neighbor
    always_comb begin
      case (item.opcode)
        OP_REM_MIN:    rem_shift[g] = 1'b1;
        OP_REM_SECOND: rem_shift[g] = (g >= 1);
        default:       rem_shift[g] = (count <= CNT_W'(g + 1));
      endcase
    end

    if (g == CAPACITY - 1) begin : g_top
      assign rem_cell[g] = cells[g];
    end else begin : g_low
      assign rem_cell[g] = rem_shift[g] ? cells[g+1] : cells[g];
    end

    // tail cell gated onto the largest-value bus
    assign tail_term[g] = cells[g] & {VALUE_W{count == CNT_W'(g + 1)}};
  end

  // largest stored value from the tail marker
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_value = tail_value | tail_term[i];
    end
  end

  // item decode: status, removed value and new count
  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    removed    = '0;
    stat       = STAT_OK;
    count_next = count;
    case (item.opcode)
      OP_INSERT: begin
        if (count >= CNT_W'(CAPACITY)) begin
          stat = STAT_FULL;
        end else begin
          do_insert  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_REM_MIN: begin
        if (count == '0) begin
          stat = STAT_FEW;
        end else begin
          do_remove  = 1'b1;
          removed    = cells[0];
          count_next = count - 1'b1;
        end
      end
      OP_REM_MAX: begin
        if (count == '0) begin
          stat = STAT_FEW;
        end else begin
          do_remove  = 1'b1;
          removed    = $signed(tail_value);
          count_next = count - 1'b1;
        end
      end
      default: begin
        if (count < CNT_W'(2)) begin
          stat = STAT_FEW;
        end else begin
          do_remove  = 1'b1;
          removed    = cells[1];
          count_next = count - 1'b1;
        end
      end
    endcase
  end

  // cell row update
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_insert) begin
          cells[i] <= ins_cell[i];
        end else if (do_remove) begin
          cells[i] <= rem_cell[i];
        end
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  // response register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.removed_value <= removed;
      rsp.status        <= stat;
      rsp.entry_count   <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sorted_list_queue.sv */
// sorted_list_queue: bounded priority queue of signed 32-bit values in ascending order
// requests insert a value or remove the smallest, largest or second-smallest value
// request channel: req_valid / req_stall / req, response channel: rsp_valid / rsp_stall / rsp
// every request item gives exactly one response item: removed value, status, entry count
// status: ok, too few entries for the removal, or store full with the insert dropped
// a request is accepted in the idle state; its response is registered by the execute step
//   once the response register is free
// an item passes through the accept step and the single execute step of the controller
//   before the next is taken; the cell row compares and shifts all entries at once
// req_stall is high while an item is being executed; one item is in flight at a time
// when rsp_stall holds a response, the next accepted item waits in its execute step
//   until the response register is taken, and req_stall stays high meanwhile
// reset (rst, synchronous, active high) empties the queue and drops any pending
//   response; the stored values themselves are not cleared
// CAPACITY sets the number of cells; entry_count reports the low 5 bits of the count
// depends on slq_pkg, slq_ctrl, slq_datapath
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire slq_pkg::req_item_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output slq_pkg::rsp_item_t      rsp
);
  import slq_pkg::*;

  slq_cmd_t cmd;

  // handshake sequencing
  slq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // sorted cell row
  slq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: an accepted item blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while another item is in flight");

  // a dropped insert removes nothing
  a_full_no_value: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STAT_FULL) |-> (rsp.removed_value == '0))
    else $error("full status with nonzero removed value");

  // a failed removal reports zero
  a_few_no_value: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STAT_FEW) |-> (rsp.removed_value == '0))
    else $error("too-few status with nonzero removed value");

  // with the response register free, the execute step registers the response
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
    else $error("response missing after accepted item");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: self-checking bench for sorted_list_queue, with a driver, a monitor and a shadow store
// a shadow sorted store predicts each response; directed items, then random phases with idling
// depends on slq_pkg and sorted_list_queue
`timescale 1ns / 1ps

module testbench;
  import slq_pkg::*;

  localparam int unsigned STORE_DEPTH = 16;
  localparam int SEND_GAP_PCT  = 62;
  localparam int RSP_STALL_PCT = 62;
  localparam int BOTH_PCT      = 7;
  localparam int HOLD_LEN      = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 380;
  localparam int MAX_REPORTS   = 100;

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RSP_STALLS,
    PH_BOTH_GAPS,
    PH_HOLD_OFF
  } traffic_phase_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  traffic_phase_t phase = PH_STEADY;
  req_item_t      items_to_send[$];
  rsp_item_t      awaited_rsps[$];
  logic           req_taken = 1'b0;
  int             hold_cycles = 0;
  int             quiet_cycles = 0;
  int             err_count = 0;

  // shadow copy of the sorted store
  logic signed [VALUE_W-1:0] store_vals[STORE_DEPTH];
  int                        store_count = 0;

  sorted_list_queue #(.CAPACITY(STORE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // pull the entry at pos out of the store, closing the gap
  function automatic logic signed [VALUE_W-1:0] take_entry(input int pos);
    logic signed [VALUE_W-1:0] v;
    v = store_vals[pos];
    for (int i = pos; i + 1 < store_count; i++) store_vals[i] = store_vals[i + 1];
    store_count--;
    return v;
  endfunction

  // apply one item to the shadow store and return the response it should give
  function automatic rsp_item_t apply_to_store(input req_item_t it);
    rsp_item_t r;
    int        pos;
    r = '0;
    r.status = STAT_OK;
    case (it.opcode)
      OP_INSERT: begin
        if (store_count >= STORE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // equal values keep arrival order: new one goes after them
          pos = 0;
          while (pos < store_count && store_vals[pos] <= it.value) pos++;
          for (int i = store_count; i > pos; i--) store_vals[i] = store_vals[i - 1];
          store_vals[pos] = it.value;
          store_count++;
        end
      end
      OP_REM_MIN: begin
        if (store_count < 1) r.status = STAT_FEW;
        else r.removed_value = take_entry(0);
      end
      OP_REM_MAX: begin
        if (store_count < 1) r.status = STAT_FEW;
        else r.removed_value = take_entry(store_count - 1);
      end
      default: begin
        if (store_count < 2) r.status = STAT_FEW;
        else r.removed_value = take_entry(1);
      end
    endcase
    r.entry_count = COUNT_W'(store_count);
    return r;
  endfunction

  function automatic bit sender_rests();
    case (phase)
      PH_SEND_GAPS: return chance(SEND_GAP_PCT);
      PH_BOTH_GAPS: return chance(BOTH_PCT);
      default:      return 1'b0;
    endcase
  endfunction

  // request driver: a presented item is held until it is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (items_to_send.size() != 0 && !sender_rests()) begin
        req       <= items_to_send.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response side stalls, including one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall   <= 1'b0;
      hold_cycles <= 0;
    end else begin
      case (phase)
        PH_RSP_STALLS: rsp_stall <= chance(RSP_STALL_PCT);
        PH_BOTH_GAPS:  rsp_stall <= chance(BOTH_PCT);
        PH_HOLD_OFF:   rsp_stall <= (hold_cycles < HOLD_LEN);
        default:       rsp_stall <= 1'b0;
      endcase
      if (phase != PH_HOLD_OFF) hold_cycles <= 0;
      else if (hold_cycles < HOLD_LEN) hold_cycles <= hold_cycles + 1;
    end
  end

  // monitor: check responses against the oldest prediction, predict accepted items
  always @(posedge clk) begin : monitor
    rsp_item_t want;
    bit        bad;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        bad = 1'b0;
        if (awaited_rsps.size() == 0) begin
          bad = 1'b1;
          if (err_count < MAX_REPORTS)
            $error("response with no item pending: removed_value %0d status %0d count %0d",
                   rsp.removed_value, rsp.status, rsp.entry_count);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.removed_value !== want.removed_value) begin
            bad = 1'b1;
            if (err_count < MAX_REPORTS)
              $error("removed_value: expected %0d, got %0d", want.removed_value,
                     rsp.removed_value);
          end
          if (rsp.status !== want.status) begin
            bad = 1'b1;
            if (err_count < MAX_REPORTS)
              $error("status: expected %0d, got %0d", want.status, rsp.status);
          end
          if (rsp.entry_count !== want.entry_count) begin
            bad = 1'b1;
            if (err_count < MAX_REPORTS)
              $error("entry_count: expected %0d, got %0d", want.entry_count,
                     rsp.entry_count);
          end
        end
        if (bad) err_count = err_count + 1;
      end
      if (req_valid && !req_stall) awaited_rsps.push_back(apply_to_store(req));
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic signed [VALUE_W-1:0] v);
    req_item_t it;
    it.opcode = op;
    it.value  = v;
    items_to_send.push_back(it);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed($urandom_range(8)) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  // random items in alternating fill and drain stretches so the store
  // swings between empty and full
  task automatic queue_random_items(input int count);
    int         mood_left;
    bit         filling;
    logic [1:0] op;
    filling   = $urandom_range(1);
    mood_left = 0;
    for (int n = 0; n < count; n++) begin
      if (mood_left == 0) begin
        filling   = ~filling;
        mood_left = $urandom_range(40, 8);
      end
      mood_left--;
      if (chance(filling ? 70 : 25)) begin
        op = OP_INSERT;
      end else begin
        case ($urandom_range(2))
          0:       op = OP_REM_MIN;
          1:       op = OP_REM_MAX;
          default: op = OP_REM_SECOND;
        endcase
      end
      queue_item(op, pick_value());
    end
  endtask

  // sender pauses here until every predicted response has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (items_to_send.size() != 0 || req_valid || awaited_rsps.size() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // removals from an empty store
    queue_item(OP_REM_MIN, 32'sd5);
    queue_item(OP_REM_MAX, -32'sd1);
    queue_item(OP_REM_SECOND, 32'sh7fff_ffff);
    // second-smallest with a single entry, then empty it from the top
    queue_item(OP_INSERT, 32'sd7);
    queue_item(OP_REM_SECOND, 32'sd0);
    queue_item(OP_REM_MAX, 32'sd0);
    // fill to capacity with extremes and duplicates
    queue_item(OP_INSERT, 32'sh7fff_ffff);
    queue_item(OP_INSERT, 32'sh8000_0000);
    queue_item(OP_INSERT, 32'sd0);
    queue_item(OP_INSERT, -32'sd1);
    queue_item(OP_INSERT, 32'sd1);
    queue_item(OP_INSERT, 32'sd0);
    queue_item(OP_INSERT, 32'sh8000_0000);
    queue_item(OP_INSERT, 32'sh7fff_ffff);
    for (int n = 0; n < 8; n++) queue_item(OP_INSERT, $signed($urandom));
    // insert into a full store is dropped
    queue_item(OP_INSERT, 32'sd42);
    queue_item(OP_REM_SECOND, 32'sd0);
    queue_item(OP_REM_MAX, 32'sd0);
    queue_item(OP_REM_MIN, 32'sd0);
    wait_drained();

    phase = PH_STEADY;
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    phase = PH_SEND_GAPS;
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    phase = PH_RSP_STALLS;
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    phase = PH_BOTH_GAPS;
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    // long response hold-off while items keep coming, block backs up
    phase = PH_HOLD_OFF;
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
